>>> rtl/ffha_pkg.sv
// types, constants and codes shared by the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

	localparam int POOL_BYTES    = 65536;
	localparam int GRANULE_BYTES = 8;
	localparam int HEADER_BYTES  = 32;
	localparam int TAG_BYTES     = 8;

	localparam int NGRAN     = POOL_BYTES / GRANULE_BYTES;
	localparam int GW        = $clog2(NGRAN);
	localparam int SW        = GW + 1;
	localparam int GSH       = $clog2(GRANULE_BYTES);
	localparam int OVH_BYTES = HEADER_BYTES + TAG_BYTES;
	localparam int SPLIT_G   = OVH_BYTES / GRANULE_BYTES;
	localparam int BW        = 17;
	localparam int OW        = 16;
	localparam int EPW       = 4;
	localparam int NEEDW     = BW + 2;
	localparam int NGW       = NEEDW - GSH;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_DFREE = 2'd3;

	typedef struct packed {
		logic          ok;
		logic [GW-1:0] idx;
	} link_t;

	typedef struct packed {
		logic          free;
		logic [SW-1:0] size;
	} fs_t;

	typedef struct packed {
		fs_t            fs;
		link_t          pv;
		link_t          nx;
		logic [EPW-1:0] ep;
	} rec_t;

endpackage

>>> rtl/first_fit_heap_allocator.sv
// first-fit heap allocator: free list walk and boundary-tag merge over granule memories
// allocate: walks the free list record by record, then splits the chunk when needed
// free: frees a checked chunk, then steps backward and merges forward through the tags
// one item at a time; the record memory port sets the pace, one access per cycle
// reset: a pass clears the chunk-start marks of all 8192 granules, then builds the pool
// the same pass runs again on every fifteenth clear when the mark epoch wraps
`timescale 1ns / 1ps
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [BW-1:0] cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    operation,
	input  logic [BW-1:0] request_bytes,
	input  logic [OW-1:0] free_offset,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic [OW-1:0] payload_offset,
	output logic [BW-1:0] used_bytes,
	output logic [BW-1:0] payload_bytes
);

	localparam logic [4:0] S_SWEEP = 5'd0;
	localparam logic [4:0] S_CLR   = 5'd1;
	localparam logic [4:0] S_IDLE  = 5'd2;
	localparam logic [4:0] S_DONE  = 5'd3;
	localparam logic [4:0] S_ACHK  = 5'd4;
	localparam logic [4:0] S_WALK  = 5'd5;
	localparam logic [4:0] S_SPL   = 5'd6;
	localparam logic [4:0] S_UPV   = 5'd7;
	localparam logic [4:0] S_UNX   = 5'd8;
	localparam logic [4:0] S_AFIN  = 5'd9;
	localparam logic [4:0] S_FCHK  = 5'd10;
	localparam logic [4:0] S_FRD   = 5'd11;
	localparam logic [4:0] S_FP1   = 5'd12;
	localparam logic [4:0] S_FP2   = 5'd13;
	localparam logic [4:0] S_BTAG  = 5'd14;
	localparam logic [4:0] S_BT2   = 5'd15;
	localparam logic [4:0] S_BR    = 5'd16;
	localparam logic [4:0] S_MP    = 5'd17;
	localparam logic [4:0] S_MS    = 5'd18;
	localparam logic [4:0] S_MCHK  = 5'd19;
	localparam logic [4:0] S_MRD   = 5'd20;
	localparam logic [4:0] S_MADD  = 5'd21;
	localparam logic [4:0] S_MEND  = 5'd22;

	localparam logic [EPW-1:0] EP_MAX = '1;
	localparam logic [EPW-1:0] EP_ONE = EPW'(1);

	// granule memories
	fs_t            mem_fs [NGRAN];
	link_t          mem_pv [NGRAN];
	link_t          mem_nx [NGRAN];
	logic [EPW-1:0] mem_ep [NGRAN];
	logic [GW-1:0]  mem_tag [NGRAN];

	logic [4:0]     state_q;
	logic [BW-1:0]  req_q;
	logic [OW-1:0]  off_q;
	logic [GW-1:0]  c_q;
	rec_t           cur_q;
	rec_t           rd_q;
	logic [GW-1:0]  tag_rd_q;
	logic           split_q;
	logic [GW-1:0]  rest_q;
	logic [SW-1:0]  take_q;
	logic           ret_q;
	logic [GW-1:0]  p0_q;
	logic [GW-1:0]  p1_q;
	logic [GW-1:0]  t_q;
	logic [SW-1:0]  n_q;
	logic [SW-1:0]  psz_q;
	logic [GW-1:0]  head_q;
	logic           head_ok_q;
	logic [BW-1:0]  used_q;
	logic [BW-1:0]  payl_q;
	logic [SW-1:0]  active_q;
	logic [BW-1:0]  pool_q;
	logic [EPW-1:0] ep_q;
	logic [GW-1:0]  sweep_q;
	logic           rpt_q;
	logic [1:0]     st_q;
	logic [OW-1:0]  offres_q;
	logic           out_valid_q;
	logic [1:0]     status_q;
	logic [OW-1:0]  payload_offset_q;
	logic [BW-1:0]  used_bytes_q;
	logic [BW-1:0]  payload_bytes_q;

	logic           we_fs, we_pv, we_nx, we_ep, tw_en;
	logic [GW-1:0]  wa, twa, twd, ra, tra;
	fs_t            wfs;
	link_t          wpv, wnx;
	logic [EPW-1:0] wep;

	logic [NEEDW-1:0] need_b;
	logic [NGW-1:0]   need_g;
	logic [SW-1:0]    used_g;
	logic [SW-1:0]    room_g;
	logic [SW-1:0]    rem_g;
	logic [BW-1:0]    clr_b;
	logic [SW-1:0]    clr_g;
	logic [OW-1:0]    offm;
	logic [GW-1:0]    fc;
	link_t            nx_rep, pv_rep;
	logic [BW-1:0]    take_b;
	logic [BW-1:0]    cur_b;
	logic [BW:0]      res_off;

	assign need_b = NEEDW'(req_q) + NEEDW'(OVH_BYTES + GRANULE_BYTES - 1);
	assign need_g = need_b[NEEDW-1:GSH];
	assign used_g = used_q[BW-1:GSH];
	assign room_g = active_q - used_g;
	assign rem_g  = rd_q.fs.size - need_g[SW-1:0];
	assign clr_b  = (pool_q > BW'(POOL_BYTES)) ? BW'(POOL_BYTES) : pool_q;
	assign clr_g  = (clr_b[BW-1:GSH] == '0) ? SW'(1) : clr_b[BW-1:GSH];
	assign offm   = off_q - OW'(HEADER_BYTES);
	assign fc     = offm[GSH+GW-1:GSH];
	assign nx_rep = split_q ? '{ok: 1'b1, idx: rest_q} : cur_q.nx;
	assign pv_rep = split_q ? '{ok: 1'b1, idx: rest_q} : cur_q.pv;
	assign take_b = BW'(take_q) << GSH;
	assign cur_b  = BW'(cur_q.fs.size) << GSH;
	assign res_off = ((BW+1)'(c_q) << GSH) + (BW+1)'(HEADER_BYTES);

	always_comb begin
		we_fs = 1'b0;
		we_pv = 1'b0;
		we_nx = 1'b0;
		we_ep = 1'b0;
		tw_en = 1'b0;
		wa    = '0;
		wfs   = '0;
		wpv   = '0;
		wnx   = '0;
		wep   = '0;
		twa   = '0;
		twd   = '0;
		ra    = '0;
		tra   = '0;
		unique case (state_q)
			S_SWEEP: begin
				we_ep = 1'b1;
				wa    = sweep_q;
			end
			S_CLR: begin
				we_fs = 1'b1;
				we_pv = 1'b1;
				we_nx = 1'b1;
				we_ep = 1'b1;
				wfs   = '{free: 1'b1, size: clr_g};
				wep   = ep_q;
				tw_en = 1'b1;
				twa   = GW'(clr_g - SW'(1));
			end
			S_ACHK: ra = head_q;
			S_WALK: ra = rd_q.nx.idx;
			S_SPL: begin
				we_fs = 1'b1;
				we_pv = 1'b1;
				we_nx = 1'b1;
				we_ep = 1'b1;
				wa    = rest_q;
				wfs   = '{free: 1'b1, size: cur_q.fs.size - take_q};
				wpv   = cur_q.pv;
				wnx   = cur_q.nx;
				wep   = ep_q;
				tw_en = 1'b1;
				twa   = GW'(SW'(c_q) + cur_q.fs.size - SW'(1));
				twd   = rest_q;
			end
			S_UPV: begin
				we_nx = cur_q.pv.ok;
				wa    = cur_q.pv.idx;
				wnx   = nx_rep;
			end
			S_UNX: begin
				we_pv = cur_q.nx.ok;
				wa    = cur_q.nx.idx;
				wpv   = pv_rep;
			end
			S_AFIN: begin
				we_fs = 1'b1;
				wa    = c_q;
				wfs   = '{free: 1'b0, size: take_q};
				tw_en = 1'b1;
				twa   = GW'(SW'(c_q) + take_q - SW'(1));
				twd   = c_q;
			end
			S_FCHK: ra = fc;
			S_FP1: begin
				we_fs = 1'b1;
				we_pv = 1'b1;
				we_nx = 1'b1;
				wa    = c_q;
				wfs   = '{free: 1'b1, size: cur_q.fs.size};
				wnx   = '{ok: head_ok_q, idx: head_q};
			end
			S_FP2: begin
				we_pv = head_ok_q;
				wa    = head_q;
				wpv   = '{ok: 1'b1, idx: c_q};
			end
			S_BTAG: tra = p0_q - GW'(1);
			S_BT2: ra = tag_rd_q;
			S_MP: ra = p1_q;
			S_MCHK: ra = n_q[GW-1:0];
			S_MADD: begin
				we_ep = 1'b1;
				wa    = n_q[GW-1:0];
			end
			S_MEND: begin
				we_fs = 1'b1;
				wa    = p1_q;
				wfs   = '{free: 1'b1, size: psz_q};
				tw_en = 1'b1;
				twa   = GW'(SW'(p1_q) + psz_q - SW'(1));
				twd   = p1_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_fs) mem_fs[wa] <= wfs;
		if (we_pv) mem_pv[wa] <= wpv;
		if (we_nx) mem_nx[wa] <= wnx;
		if (we_ep) mem_ep[wa] <= wep;
		if (tw_en) mem_tag[twa] <= twd;
		rd_q     <= '{fs: mem_fs[ra], pv: mem_pv[ra], nx: mem_nx[ra], ep: mem_ep[ra]};
		tag_rd_q <= mem_tag[tra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			rpt_q       <= 1'b0;
			ep_q        <= '0;
			pool_q      <= BW'(POOL_BYTES);
			head_q      <= '0;
			head_ok_q   <= 1'b1;
			used_q      <= '0;
			payl_q      <= '0;
			active_q    <= SW'(NGRAN);
			out_valid_q <= 1'b0;
			split_q     <= 1'b0;
			ret_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) pool_q <= cfg_data;
			if (out_valid_q && !out_stall && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + GW'(1);
					if (sweep_q == '1) begin
						ep_q    <= EP_ONE;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					head_q    <= '0;
					head_ok_q <= 1'b1;
					used_q    <= '0;
					payl_q    <= '0;
					active_q  <= clr_g;
					st_q      <= ST_OK;
					offres_q  <= '0;
					state_q   <= rpt_q ? S_DONE : S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q <= request_bytes;
						off_q <= free_offset;
						unique case (operation)
							OP_ALLOC: state_q <= S_ACHK;
							OP_FREE: state_q <= S_FCHK;
							OP_CLEAR: begin
								rpt_q <= 1'b1;
								if (ep_q == EP_MAX) begin
									sweep_q <= '0;
									state_q <= S_SWEEP;
								end else begin
									ep_q    <= ep_q + EP_ONE;
									state_q <= S_CLR;
								end
							end
							OP_NONE: begin
								st_q     <= ST_OK;
								offres_q <= '0;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q      <= 1'b1;
						status_q         <= st_q;
						payload_offset_q <= offres_q;
						used_bytes_q     <= used_q;
						payload_bytes_q  <= payl_q;
						state_q          <= S_IDLE;
					end
				end
				S_ACHK: begin
					offres_q <= '0;
					priority if (req_q == '0 || need_g > NGW'(active_q)) begin
						st_q    <= ST_BAD;
						state_q <= S_DONE;
					end else if (NGW'(room_g) < need_g || !head_ok_q) begin
						st_q    <= ST_NOFIT;
						state_q <= S_DONE;
					end else begin
						c_q     <= head_q;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					priority if (NGW'(rd_q.fs.size) >= need_g) begin
						cur_q <= rd_q;
						ret_q <= 1'b0;
						rest_q <= c_q + GW'(need_g);
						if (rem_g > SW'(SPLIT_G)) begin
							split_q <= 1'b1;
							take_q  <= need_g[SW-1:0];
							state_q <= S_SPL;
						end else begin
							split_q <= 1'b0;
							take_q  <= rd_q.fs.size;
							state_q <= S_UPV;
						end
					end else if (rd_q.nx.ok) begin
						c_q <= rd_q.nx.idx;
					end else begin
						st_q    <= ST_NOFIT;
						state_q <= S_DONE;
					end
				end
				S_SPL: state_q <= S_UPV;
				S_UPV: begin
					if (!cur_q.pv.ok) begin
						head_ok_q <= nx_rep.ok;
						head_q    <= nx_rep.idx;
					end
					state_q <= S_UNX;
				end
				S_UNX: state_q <= ret_q ? S_MADD : S_AFIN;
				S_AFIN: begin
					used_q   <= used_q + take_b;
					payl_q   <= payl_q + take_b - BW'(OVH_BYTES);
					st_q     <= ST_OK;
					offres_q <= res_off[OW-1:0];
					state_q  <= S_DONE;
				end
				S_FCHK: begin
					offres_q <= '0;
					priority if (off_q < OW'(HEADER_BYTES)
						|| offm[GSH-1:0] != '0 || SW'(fc) >= active_q) begin
						st_q    <= ST_BAD;
						state_q <= S_DONE;
					end else begin
						c_q     <= fc;
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					priority if (rd_q.ep != ep_q) begin
						st_q    <= ST_BAD;
						state_q <= S_DONE;
					end else if (rd_q.fs.free) begin
						st_q    <= ST_DFREE;
						state_q <= S_DONE;
					end else begin
						cur_q   <= rd_q;
						state_q <= S_FP1;
					end
				end
				S_FP1: begin
					used_q  <= used_q - cur_b;
					payl_q  <= payl_q - (cur_b - BW'(OVH_BYTES));
					state_q <= S_FP2;
				end
				S_FP2: begin
					head_q    <= c_q;
					head_ok_q <= 1'b1;
					p0_q      <= c_q;
					p1_q      <= c_q;
					split_q   <= 1'b0;
					ret_q     <= 1'b1;
					state_q   <= S_BTAG;
				end
				S_BTAG: state_q <= (p0_q == '0) ? S_MP : S_BT2;
				S_BT2: begin
					t_q     <= tag_rd_q;
					state_q <= S_BR;
				end
				S_BR: begin
					if (rd_q.ep == ep_q && rd_q.fs.free) begin
						p0_q    <= t_q;
						p1_q    <= t_q;
						state_q <= S_BTAG;
					end else begin
						state_q <= S_MP;
					end
				end
				S_MP: state_q <= S_MS;
				S_MS: begin
					psz_q   <= rd_q.fs.size;
					n_q     <= SW'(p1_q) + rd_q.fs.size;
					state_q <= S_MCHK;
				end
				S_MCHK: state_q <= (n_q < active_q) ? S_MRD : S_MEND;
				S_MRD: begin
					if (rd_q.ep == ep_q && rd_q.fs.free) begin
						cur_q   <= rd_q;
						state_q <= S_UPV;
					end else begin
						state_q <= S_MEND;
					end
				end
				S_MADD: begin
					psz_q   <= psz_q + cur_q.fs.size;
					n_q     <= n_q + cur_q.fs.size;
					state_q <= S_MCHK;
				end
				S_MEND: begin
					st_q     <= ST_OK;
					offres_q <= '0;
					state_q  <= S_DONE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready      = (state_q == S_IDLE);
	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign payload_offset = payload_offset_q;
	assign used_bytes     = used_bytes_q;
	assign payload_bytes  = payload_bytes_q;

endmodule

>>> tb/sv/first_fit_heap_allocator_tb.sv
// testbench for the first-fit heap allocator: queued driver, checking monitor, heap model
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int RUN_ITEMS   = 950;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]    op;
		logic [BW-1:0] req;
		logic [OW-1:0] off;
	} heap_op_t;

	typedef struct {
		logic [1:0]    st;
		logic [OW-1:0] poff;
		logic [BW-1:0] used;
		logic [BW-1:0] pay;
	} heap_res_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [BW-1:0] cfg_data = '0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [1:0]    operation = OP_NONE;
	logic [BW-1:0] request_bytes = '0;
	logic [OW-1:0] free_offset = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [1:0]    status;
	logic [OW-1:0] payload_offset;
	logic [BW-1:0] used_bytes;
	logic [BW-1:0] payload_bytes;

	heap_op_t  op_queue[$];
	heap_res_t result_queue[$];
	int        live_offsets[$];
	int        send_idle = 0;
	int        recv_stall = 0;
	int        errors = 0;
	int        cycles = 0;

	// shadow heap
	int pool_reg = 65536;
	int act_gran, fhead, used_tot, pay_tot;
	bit fhead_ok;
	bit c_free[NGRAN];
	int c_size[NGRAN];
	bit c_hp[NGRAN];
	int c_prev[NGRAN];
	bit c_hn[NGRAN];
	int c_next[NGRAN];
	int etag[NGRAN];
	bit cstart[NGRAN];

	first_fit_heap_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .request_bytes(request_bytes), .free_offset(free_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .payload_offset(payload_offset),
		.used_bytes(used_bytes), .payload_bytes(payload_bytes)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("first_fit_heap_allocator_tb: errors");
			$finish;
		end
	end

	function automatic void set_tag(int c);
		int last;
		last = c + c_size[c] / GRANULE_BYTES - 1;
		if (last < NGRAN) etag[last] = c;
	endfunction

	function automatic void unlink(int x);
		if (c_hp[x] && c_prev[x] < NGRAN) begin
			c_hn[c_prev[x]] = c_hn[x];
			c_next[c_prev[x]] = c_next[x];
		end else begin
			fhead_ok = c_hn[x];
			fhead = c_next[x];
		end
		if (c_hn[x] && c_next[x] < NGRAN) begin
			c_hp[c_next[x]] = c_hp[x];
			c_prev[c_next[x]] = c_prev[x];
		end
	endfunction

	function automatic void clear_heap();
		int b, g;
		b = pool_reg;
		if (b > POOL_BYTES) b = POOL_BYTES;
		g = b / GRANULE_BYTES;
		if (g == 0) g = 1;
		act_gran = g;
		foreach (cstart[i]) cstart[i] = 1'b0;
		cstart[0] = 1'b1;
		c_free[0] = 1'b1;
		c_size[0] = g * GRANULE_BYTES;
		c_hp[0] = 1'b0;
		c_prev[0] = 0;
		c_hn[0] = 1'b0;
		c_next[0] = 0;
		set_tag(0);
		fhead_ok = 1'b1;
		fhead = 0;
		used_tot = 0;
		pay_tot = 0;
	endfunction

	function automatic logic [1:0] alloc_chunk(int req, output int poff);
		int need, c, steps, n, rest;
		bit ok;
		poff = 0;
		if (req == 0) return ST_BAD;
		need = (req + OVH_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;
		if (need > act_gran * GRANULE_BYTES) return ST_BAD;
		if (act_gran * GRANULE_BYTES - used_tot < need) return ST_NOFIT;
		ok = fhead_ok;
		c = fhead;
		for (steps = 0; ok && c < NGRAN && steps < NGRAN; steps++) begin
			if (c_size[c] >= need) begin
				n = need;
				if (c_size[c] - n > OVH_BYTES) begin
					rest = c + n / GRANULE_BYTES;
					if (rest >= NGRAN) return ST_NOFIT;
					c_free[rest] = c_free[c];
					c_size[rest] = c_size[c] - n;
					c_hp[rest] = c_hp[c];
					c_prev[rest] = c_prev[c];
					c_hn[rest] = c_hn[c];
					c_next[rest] = c_next[c];
					cstart[rest] = 1'b1;
					set_tag(rest);
					if (c_hp[rest] && c_prev[rest] < NGRAN) c_next[c_prev[rest]] = rest;
					else fhead = rest;
					if (c_hn[rest] && c_next[rest] < NGRAN) c_prev[c_next[rest]] = rest;
					c_free[c] = 1'b0;
					c_size[c] = n;
					set_tag(c);
				end else begin
					unlink(c);
					c_free[c] = 1'b0;
				end
				used_tot += c_size[c];
				pay_tot += c_size[c] - OVH_BYTES;
				poff = c * GRANULE_BYTES + HEADER_BYTES;
				return ST_OK;
			end
			ok = c_hn[c];
			c = c_next[c];
		end
		return ST_NOFIT;
	endfunction

	function automatic void merge_around(int c);
		int p0, p1, n, steps, t, sz;
		p0 = c;
		p1 = c;
		for (steps = 0; steps < NGRAN && c_free[p0]; steps++) begin
			p1 = p0;
			if (p0 == 0) break;
			t = etag[p0 - 1];
			if (t >= NGRAN || !cstart[t]) break;
			p0 = t;
		end
		n = p1 + c_size[p1] / GRANULE_BYTES;
		for (steps = 0; steps < NGRAN && n < act_gran && n < NGRAN && cstart[n] && c_free[n];
				steps++) begin
			sz = c_size[n];
			unlink(n);
			cstart[n] = 1'b0;
			c_size[p1] += sz;
			n += sz / GRANULE_BYTES;
		end
		set_tag(p1);
	endfunction

	function automatic logic [1:0] free_chunk(int off);
		int c;
		if (off < HEADER_BYTES || (off - HEADER_BYTES) % GRANULE_BYTES != 0) return ST_BAD;
		c = (off - HEADER_BYTES) / GRANULE_BYTES;
		if (c >= act_gran || !cstart[c]) return ST_BAD;
		if (c_free[c]) return ST_DFREE;
		// push to the front of the free list
		c_hp[c] = 1'b0;
		c_prev[c] = 0;
		c_hn[c] = fhead_ok;
		c_next[c] = fhead;
		if (fhead_ok && fhead < NGRAN) begin
			c_hp[fhead] = 1'b1;
			c_prev[fhead] = c;
		end
		fhead_ok = 1'b1;
		fhead = c;
		c_free[c] = 1'b1;
		used_tot -= c_size[c];
		pay_tot -= c_size[c] - OVH_BYTES;
		merge_around(c);
		return ST_OK;
	endfunction

	function automatic void predict_heap(heap_op_t it);
		heap_res_t r;
		int poff;
		poff = 0;
		r.st = ST_OK;
		case (it.op)
			OP_ALLOC: begin
				r.st = alloc_chunk(int'(it.req), poff);
				if (r.st == ST_OK) live_offsets.push_back(poff);
			end
			OP_FREE: begin
				r.st = free_chunk(int'(it.off));
				if (r.st == ST_OK)
					foreach (live_offsets[i])
						if (live_offsets[i] == int'(it.off)) begin
							live_offsets.delete(i);
							break;
						end
			end
			OP_CLEAR: begin
				clear_heap();
				live_offsets.delete();
			end
			default: ;
		endcase
		r.poff = poff[OW-1:0];
		r.used = used_tot[BW-1:0];
		r.pay = pay_tot[BW-1:0];
		result_queue.push_back(r);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		heap_op_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_NONE;
			request_bytes <= '0;
			free_offset <= '0;
		end else begin
			if (in_valid && !in_stall)
				predict_heap('{operation, request_bytes, free_offset});
			if (!in_valid || !in_stall) begin
				if (op_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
					nxt = op_queue.pop_front();
					in_valid <= 1'b1;
					operation <= nxt.op;
					request_bytes <= nxt.req;
					free_offset <= nxt.off;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		heap_res_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_queue.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					e = result_queue.pop_front();
					if (status !== e.st) begin
						$error("status expected %0d got %0d", e.st, status);
						errors++;
					end
					if (payload_offset !== e.poff) begin
						$error("payload_offset expected %0d got %0d", e.poff, payload_offset);
						errors++;
					end
					if (used_bytes !== e.used) begin
						$error("used_bytes expected %0d got %0d", e.used, used_bytes);
						errors++;
					end
					if (payload_bytes !== e.pay) begin
						$error("payload_bytes expected %0d got %0d", e.pay, payload_bytes);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	task automatic push_op(logic [1:0] op, int req, int off);
		op_queue.push_back('{op, req[BW-1:0], off[OW-1:0]});
	endtask

	task automatic drain();
		while (op_queue.size() != 0 || result_queue.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic write_pool(int v);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v[BW-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pool_reg = v & 32'h1FFFF;
		push_op(OP_CLEAR, 0, 0);
	endtask

	initial begin
		int pools[$];
		int r, req, off;
		pools = '{64, 65535, 4096, 512, 1000, 65536, 200};
		pool_reg = 65536;
		clear_heap();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: splits, both-side merges, whole-chunk take, errors
		push_op(OP_CLEAR, 0, 0);
		push_op(OP_ALLOC, 0, 0);
		push_op(OP_ALLOC, 65536, 0);
		push_op(OP_ALLOC, 1, 0);
		push_op(OP_ALLOC, 1, 0);
		push_op(OP_ALLOC, 100, 0);
		push_op(OP_FREE, 0, 80);
		push_op(OP_FREE, 0, 32);
		push_op(OP_FREE, 0, 128);
		push_op(OP_ALLOC, 65496, 0);
		push_op(OP_ALLOC, 1, 0);
		push_op(OP_FREE, 0, 32);
		push_op(OP_FREE, 0, 32);
		push_op(OP_FREE, 0, 0);
		push_op(OP_FREE, 0, 33);
		push_op(OP_FREE, 0, 65535);
		push_op(OP_FREE, 0, 40);
		push_op(OP_NONE, 131071, 65535);
		push_op(OP_ALLOC, 65490, 0);
		push_op(OP_ALLOC, 65000, 0);
		drain();

		for (int i = 0; i < RUN_ITEMS; i++) begin
			case (i / 238)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 79; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 79; end
				default: begin send_idle = 37; recv_stall = 37; end
			endcase
			if (i % 8 == 0) drain();
			if (i % 130 == 0 && pools.size() > 0) write_pool(pools.pop_front());
			else if (i % 130 == 65) write_pool($urandom_range(64, 65536));
			r = $urandom_range(99);
			if (r < 56) begin
				r = $urandom_range(99);
				if (r < 60) req = $urandom_range(1, 64);
				else if (r < 90) req = $urandom_range(65, 600);
				else if (r < 97) req = $urandom_range(601, 8000);
				else req = $urandom_range(0, 65536);
				push_op(OP_ALLOC, req, 0);
			end else if (r < 88) begin
				if (live_offsets.size() > 0 && $urandom_range(9) < 8)
					off = live_offsets[$urandom_range(live_offsets.size() - 1)];
				else if ($urandom_range(1))
					off = HEADER_BYTES + GRANULE_BYTES * $urandom_range(0, 8000);
				else
					off = $urandom_range(0, 65535);
				push_op(OP_FREE, 0, off);
			end else if (r < 91) begin
				push_op(OP_CLEAR, $urandom_range(0, 131071), $urandom_range(0, 65535));
			end else begin
				push_op(OP_NONE, $urandom_range(0, 131071), $urandom_range(0, 65535));
			end
		end

		drain();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("first_fit_heap_allocator_tb: clean");
		else
			$display("first_fit_heap_allocator_tb: errors");
		$finish;
	end

endmodule

>>> files.f
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
